### design/mbps_pkg.sv
package mbps_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic        found;
        logic [63:0] match_address;
    } out_word_t;

    // Control and compare operands handed to one window cell.
    typedef struct packed {
        logic       shift;
        logic       active;
        logic       care;
        logic [7:0] pattern;
    } cell_ctrl_t;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_CARE_MASK      = 3'd2,
        CFG_PATTERN_LENGTH = 3'd3,
        CFG_REGION_BASE    = 3'd4
    } cfg_index_t;

endpackage

### design/mbps_cell.sv
module mbps_cell (
    input  logic                   clk,
    input  mbps_pkg::cell_ctrl_t   ctrl,
    input  logic [7:0]             byte_in,
    output logic [7:0]             byte_out,
    output logic                   ok
);
    import mbps_pkg::*;

    logic [7:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // A cell beyond the used length or under a wildcard always agrees.
    assign ok = !ctrl.active || !ctrl.care || (byte_reg == ctrl.pattern);

endmodule

### design/mbps_chain.sv
module mbps_chain #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                        clk,
    input  logic                        shift,
    input  logic [7:0]                  data_byte,
    input  logic [PATTERN_MAX-1:0][7:0] pattern,
    input  logic [PATTERN_MAX-1:0]      care,
    input  logic [4:0]                  len,
    output logic                        hit
);
    import mbps_pkg::*;

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [PATTERN_MAX-1:0][7:0] link;
    logic [PATTERN_MAX-1:0]      ok_vec;

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            cell_ctrl_t ctrl;
            logic [4:0] idx_full;
            logic [IDX_W-1:0] idx;
            logic [7:0] byte_in;

            // Cell k holds the byte k places back, which lines up with
            // pattern byte len-1-k.
            assign idx_full = len - 5'(k) - 5'd1;
            assign idx      = idx_full[IDX_W-1:0];

            always_comb
            begin
                ctrl.shift   = shift;
                ctrl.active  = (5'(k) < len);
                ctrl.care    = ctrl.active ? care[idx] : 1'b0;
                ctrl.pattern = ctrl.active ? pattern[idx] : 8'd0;
            end

            if (k == 0)
            begin : g_head
                assign byte_in = data_byte;
            end
            else
            begin : g_body
                assign byte_in = link[k-1];
            end

            mbps_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .byte_in  (byte_in),
                .byte_out (link[k]),
                .ok       (ok_vec[k])
            );
        end
    endgenerate

    assign hit = &ok_vec;

endmodule

### design/masked_byte_pattern_scan.sv
// Masked byte pattern scan.
// The src channel takes one word per byte of a memory region, in ascending
// address order, with last_byte set on the final byte. Words move on a rising
// edge with valid high and stall low. The block searches the region for the
// configured pattern (up to PATTERN_MAX bytes, wildcards where care_mask is
// clear) and gives at most one dst word per region: found with the address
// of the first match, or not found (address 0) after the last byte. Bytes
// after a match give nothing; the last byte arms the block for the next region.
// Throughput is one byte per cycle unless src stalls: the window is a row of
// cells that shift together, and each cell compares its byte in parallel with
// the others. Stage two registers the compare with offset subtract, stage three
// adds the base address. Configuration goes through the cfg channel (always
// ready); the user writes it only while no region is in flight, unchecked by
// the block. When dst stalls, the result waits in the output register and the
// pipeline keeps filling; src stall rises once every stage is occupied. Reset
// clears the byte counter, the match flag and all pipeline valids.
module masked_byte_pattern_scan #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  src_valid,
    output logic                                  src_stall,
    input  mbps_pkg::in_word_t                    src_word,
    output logic                                  dst_valid,
    input  logic                                  dst_stall,
    output mbps_pkg::out_word_t                   dst_word,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [63:0]                           cfg_data
);
    import mbps_pkg::*;

    localparam logic [63:0] COUNT_MAX = '1;

    logic [63:0] pattern_low_reg;
    logic [63:0] pattern_high_reg;
    logic [15:0] care_mask_reg;
    logic [4:0]  pattern_length_reg;
    logic [63:0] region_base_reg;

    logic [4:0]   len_used;
    logic [127:0] pattern_full;

    logic        src_accept;
    logic [63:0] count_reg;
    logic [63:0] count_next;
    logic        ge_next;

    logic        s1_valid_reg;
    logic        s1_last_reg;
    logic        s1_ge_reg;
    logic [63:0] s1_count_reg;
    logic        s1_fire;
    logic        window_hit;
    logic        hit;
    logic        not_found;

    logic        rep_reg;

    logic        s2_valid_reg;
    logic        s2_found_reg;
    logic [63:0] s2_off_reg;
    logic        s2_ready;

    logic        out_ready;
    logic        dst_valid_reg;
    out_word_t   dst_word_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= 16'hFFFF;
            pattern_length_reg <= 5'd1;
            region_base_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                CFG_CARE_MASK:      care_mask_reg      <= cfg_data[15:0];
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[4:0];
                CFG_REGION_BASE:    region_base_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        if (pattern_length_reg == 5'd0)
        begin
            len_used = 5'd1;
        end
        else if (pattern_length_reg > 5'(PATTERN_MAX))
        begin
            len_used = 5'(PATTERN_MAX);
        end
        else
        begin
            len_used = pattern_length_reg;
        end
    end

    assign pattern_full = {pattern_high_reg, pattern_low_reg};

    // Handshake chain: a stage may load when it is empty or draining.
    assign out_ready  = !dst_valid_reg || !dst_stall;
    assign s2_ready   = !s2_valid_reg || out_ready;
    assign s1_fire    = s1_valid_reg && s2_ready;
    assign src_stall  = s1_valid_reg && !s2_ready;
    assign src_accept = src_valid && !src_stall;

    // Stage one: window shift and saturating byte count.
    assign count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 64'd1;
    assign ge_next    = (|count_next[63:5]) || (count_next[4:0] >= len_used);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (src_accept)
            begin
                count_reg    <= src_word.last_byte ? 64'd0 : count_next;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_accept)
        begin
            s1_last_reg  <= src_word.last_byte;
            s1_ge_reg    <= ge_next;
            s1_count_reg <= count_next;
        end
    end

    mbps_chain #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_chain (
        .clk       (clk),
        .shift     (src_accept),
        .data_byte (src_word.data_byte),
        .pattern   (pattern_full[8*PATTERN_MAX-1:0]),
        .care      (care_mask_reg[PATTERN_MAX-1:0]),
        .len       (len_used),
        .hit       (window_hit)
    );

    // Stage two: match decision, in byte order, so the reported flag is exact.
    assign hit       = !rep_reg && s1_ge_reg && window_hit;
    assign not_found = !rep_reg && s1_last_reg && !hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_reg      <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                s2_valid_reg <= hit || not_found;
                if (s1_last_reg)
                begin
                    rep_reg <= 1'b0;
                end
                else if (hit)
                begin
                    rep_reg <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_found_reg <= hit;
            s2_off_reg   <= s1_count_reg - {59'd0, len_used};
        end
    end

    // Stage three: output register with the base address added.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            dst_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg)
        begin
            dst_word_reg.found         <= s2_found_reg;
            dst_word_reg.match_address <= s2_found_reg ? region_base_reg + s2_off_reg : 64'd0;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_word  = dst_word_reg;

    a_not_found_zero : assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_word.found |-> dst_word.match_address == 64'd0)
        else $error("not-found word carries a nonzero address");

    a_stall_needs_full : assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> s1_valid_reg && s2_valid_reg && dst_valid_reg)
        else $error("src stalled with a free pipeline stage");

    a_miss_only_on_last : assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !s1_last_reg |=> !s2_valid_reg || s2_found_reg)
        else $error("not-found result from a byte that is not the last");

    a_hit_sets_flag : assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && hit && !s1_last_reg |=> rep_reg)
        else $error("match did not mark the region as reported");

endmodule
